// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file ars_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Property checked only while reset is low.
`define ASSERT_ON(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// File: rtl/core/ars_pkg.sv
// Types and constants of the acknowledged-retransmission slot manager.
`timescale 1ns / 1ps

package ars_pkg;

  // Buffer sizing used by the send length check
  localparam int BUFFER_BYTES    = 60;
  localparam int HEADER_OVERHEAD = 16;

  // Field widths
  localparam int TIMER_W  = 8;
  localparam int MAG_W    = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Operation codes
  localparam logic [1:0] OP_SEND = 2'd0;
  localparam logic [1:0] OP_ACK  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  // Result action codes
  localparam logic [3:0] ACT_ACCEPTED   = 4'd0;
  localparam logic [3:0] ACT_NOSLOT     = 4'd1;
  localparam logic [3:0] ACT_TOOLONG    = 4'd2;
  localparam logic [3:0] ACT_ACKED      = 4'd3;
  localparam logic [3:0] ACT_UNMATCHED  = 4'd4;
  localparam logic [3:0] ACT_TRANSMIT   = 4'd5;
  localparam logic [3:0] ACT_RETRANSMIT = 4'd6;
  localparam logic [3:0] ACT_NAMEREQ    = 4'd7;
  localparam logic [3:0] ACT_UIDREQ     = 4'd8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SEND_PERIOD      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEND_ATTEMPTS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESOLVE_PERIOD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RESOLVE_ATTEMPTS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ID_FIXED_MASK    = 3'd4;

  // Register reset values
  localparam logic [6:0]  RST_SEND_PERIOD      = 7'd10;
  localparam logic [6:0]  RST_SEND_ATTEMPTS    = 7'd3;
  localparam logic [6:0]  RST_RESOLVE_PERIOD   = 7'd10;
  localparam logic [6:0]  RST_RESOLVE_ATTEMPTS = 7'd3;
  localparam logic [15:0] RST_ID_FIXED_MASK    = 16'hFF00;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] dest_handle;
    logic [7:0]  payload_len;
    logic [15:0] new_id;
    logic        dest_known;
    logic [15:0] ack_id;
    logic [7:0]  lookup_hits;
  } request_t;

  typedef struct packed {
    logic [2:0]  slot_index;
    logic [3:0]  action;
    logic [15:0] msg_id;
    logic [15:0] dest_out;
    logic        last;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEND,
    ST_SEND2,
    ST_ACK,
    ST_TICK,
    ST_TICK_WAIT,
    ST_FLUSH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic cur_clear;
    logic cur_inc;
    logic send_exec;
    logic send_second;
    logic ack_step;
    logic tick_eval;
    logic tick_finish;
    logic flush;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] req_op;
    logic       send_ok;
    logic       ack_match;
    logic       cur_last;
    logic       tick_needs_mod;
    logic       mod_done;
  } dp_stat_t;

endpackage

// File: rtl/core/ars_mod_unit.sv
// Iterative remainder unit: one quotient bit per cycle, flags a zero remainder.
`timescale 1ns / 1ps

module ars_mod_unit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [ars_pkg::MAG_W-1:0] dividend,
  input  logic [ars_pkg::MAG_W-1:0] divisor,
  output logic                     done,
  output logic                     rem_zero
);

  localparam int CNT_W = $clog2(ars_pkg::MAG_W);
  localparam int W     = ars_pkg::MAG_W;

  logic             active;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     q;
  logic [W-1:0]     r;
  logic [W-1:0]     d;
  logic [W:0]       r_sh;
  logic [W:0]       r_sub;
  logic [W-1:0]     r_next;

  // One restoring step
  always_comb begin
    r_sh   = {r, q[W-1]};
    r_sub  = r_sh - {1'b0, d};
    r_next = (r_sh >= {1'b0, d}) ? r_sub[W-1:0] : r_sh[W-1:0];
  end

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // Operand and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      r <= '0;
      d <= divisor;
    end else if (active) begin
      q <= {q[W-2:0], 1'b0};
      r <= r_next;
    end
  end

  assign rem_zero = (r == '0);

endmodule

// File: rtl/core/ars_datapath.sv
// Slot registers, configuration registers, result hold stage and output register.
`timescale 1ns / 1ps

module ars_datapath #(
  parameter int SLOTS = 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ars_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ars_pkg::CFG_DATA_W-1:0] cfg_data,
  input  ars_pkg::request_t             request,
  input  ars_pkg::dp_cmd_t              cmd,
  output ars_pkg::dp_stat_t             stat,
  output ars_pkg::result_t              result,
  output logic                          strobe
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TW    = ars_pkg::TIMER_W;
  localparam int MW    = ars_pkg::MAG_W;

  // Configuration
  logic [6:0]  send_period;
  logic [6:0]  send_attempts;
  logic [6:0]  resolve_period;
  logic [6:0]  resolve_attempts;
  logic [15:0] id_fixed_mask;

  // Slot state
  logic [TW-1:0] timer [SLOTS];
  logic [15:0]   sid   [SLOTS];
  logic [15:0]   sdest [SLOTS];

  ars_pkg::request_t req;
  logic [IDX_W-1:0]  cur;
  logic              kind_resolve;

  // Hold stage: a result waits here until the next one shows whether it is last
  logic              pend_valid;
  ars_pkg::result_t  pend;
  logic              push;
  ars_pkg::result_t  push_item;

  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic [8:0]       len_sum;
  logic             too_long;
  logic [13:0]      prod_send;
  logic [13:0]      prod_res;
  logic [MW-1:0]    sat_send;
  logic [MW-1:0]    sat_res;
  logic [TW-1:0]    timer_send;
  logic [TW-1:0]    timer_res;
  logic [MW-1:0]    eff_sp;
  logic [MW-1:0]    eff_rp;
  logic [TW-1:0]    t_cur;
  logic             t_zero;
  logic             t_neg;
  logic [TW-1:0]    t_step;
  logic [TW-1:0]    t_step_neg;
  logic [SLOTS-1:0] hits;
  logic             hit;
  logic [15:0]      id_cur;
  logic [15:0]      id_bumped;
  logic             ack_match;
  logic             mod_start;
  logic [MW-1:0]    mod_dividend;
  logic [MW-1:0]    mod_divisor;
  logic             mod_done;
  logic             mod_zero;

  // Lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (timer[i] == '0) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // Length check and saturated timer loads
  always_comb begin
    len_sum    = 9'(req.payload_len) + 9'(ars_pkg::HEADER_OVERHEAD);
    too_long   = len_sum > 9'(ars_pkg::BUFFER_BYTES);
    prod_send  = send_period * send_attempts;
    prod_res   = resolve_period * resolve_attempts;
    sat_send   = (prod_send > 14'd127) ? 7'd127 : prod_send[MW-1:0];
    sat_res    = (prod_res > 14'd127) ? 7'd127 : prod_res[MW-1:0];
    timer_send = {1'b0, sat_send};
    timer_res  = '0 - {1'b0, sat_res};
    eff_sp     = (send_period == '0) ? 7'd1 : send_period;
    eff_rp     = (resolve_period == '0) ? 7'd1 : resolve_period;
  end

  // Current slot view
  always_comb begin
    t_cur      = timer[cur];
    t_zero     = (t_cur == '0);
    t_neg      = t_cur[TW-1];
    t_step     = t_neg ? (t_cur + TW'(1)) : (t_cur - TW'(1));
    t_step_neg = '0 - t_step;
    hits       = req.lookup_hits[SLOTS-1:0];
    hit        = hits[cur];
    id_cur     = sid[cur];
    id_bumped  = (id_cur & id_fixed_mask) | (((id_cur | id_fixed_mask) + 16'd1) & ~id_fixed_mask);
    ack_match  = ((req.ack_id ^ id_cur) & id_fixed_mask) == '0;
  end

  // Remainder check of the stepped timer magnitude
  assign mod_start    = cmd.tick_eval && !t_zero && !(t_neg && hit);
  assign mod_dividend = t_neg ? t_step_neg[MW-1:0] : t_step[MW-1:0];
  assign mod_divisor  = t_neg ? eff_rp : eff_sp;

  ars_mod_unit u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_dividend),
    .divisor  (mod_divisor),
    .done     (mod_done),
    .rem_zero (mod_zero)
  );

  // Status to the controller
  always_comb begin
    stat.req_op         = request.op;
    stat.send_ok        = free_found && !too_long;
    stat.ack_match      = ack_match;
    stat.cur_last       = (cur == IDX_W'(SLOTS - 1));
    stat.tick_needs_mod = !t_zero && !(t_neg && hit);
    stat.mod_done       = mod_done;
  end

  // Result selection
  always_comb begin
    push                 = 1'b0;
    push_item            = '0;
    push_item.slot_index = 3'(cur);
    push_item.msg_id     = id_cur;
    push_item.dest_out   = sdest[cur];
    if (cmd.send_exec) begin
      push               = 1'b1;
      push_item.msg_id   = req.new_id;
      push_item.dest_out = req.dest_handle;
      if (!free_found) begin
        push_item.slot_index = '0;
        push_item.action     = ars_pkg::ACT_NOSLOT;
      end else if (too_long) begin
        push_item.slot_index = 3'(free_idx);
        push_item.action     = ars_pkg::ACT_TOOLONG;
      end else begin
        push_item.slot_index = 3'(free_idx);
        push_item.action     = ars_pkg::ACT_ACCEPTED;
      end
    end else if (cmd.send_second) begin
      push               = 1'b1;
      push_item.msg_id   = req.new_id;
      push_item.dest_out = req.dest_handle;
      push_item.action   = req.dest_known ? ars_pkg::ACT_TRANSMIT : ars_pkg::ACT_NAMEREQ;
    end else if (cmd.ack_step) begin
      if (ack_match) begin
        push             = 1'b1;
        push_item.action = ars_pkg::ACT_ACKED;
      end else if (stat.cur_last) begin
        push                 = 1'b1;
        push_item.slot_index = '0;
        push_item.action     = ars_pkg::ACT_UNMATCHED;
        push_item.msg_id     = req.ack_id;
        push_item.dest_out   = '0;
      end
    end else if (cmd.tick_eval) begin
      if (t_neg && hit) begin
        push             = 1'b1;
        push_item.action = ars_pkg::ACT_TRANSMIT;
      end
    end else if (cmd.tick_finish) begin
      if (mod_zero) begin
        push = 1'b1;
        if (kind_resolve) begin
          push_item.action = ars_pkg::ACT_NAMEREQ;
        end else if (hit) begin
          push_item.action = ars_pkg::ACT_RETRANSMIT;
          push_item.msg_id = id_bumped;
        end else begin
          push_item.action = ars_pkg::ACT_UIDREQ;
        end
      end
    end
  end

  // Configuration, slot timers and walk index
  always_ff @(posedge clk) begin
    if (rst) begin
      send_period      <= ars_pkg::RST_SEND_PERIOD;
      send_attempts    <= ars_pkg::RST_SEND_ATTEMPTS;
      resolve_period   <= ars_pkg::RST_RESOLVE_PERIOD;
      resolve_attempts <= ars_pkg::RST_RESOLVE_ATTEMPTS;
      id_fixed_mask    <= ars_pkg::RST_ID_FIXED_MASK;
      cur              <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        timer[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ars_pkg::CFG_SEND_PERIOD:      send_period      <= cfg_data[6:0];
          ars_pkg::CFG_SEND_ATTEMPTS:    send_attempts    <= cfg_data[6:0];
          ars_pkg::CFG_RESOLVE_PERIOD:   resolve_period   <= cfg_data[6:0];
          ars_pkg::CFG_RESOLVE_ATTEMPTS: resolve_attempts <= cfg_data[6:0];
          ars_pkg::CFG_ID_FIXED_MASK:    id_fixed_mask    <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.cur_clear) begin
        cur <= '0;
      end else if (cmd.cur_inc) begin
        cur <= cur + IDX_W'(1);
      end else if (cmd.send_exec) begin
        cur <= free_idx;
      end
      if (cmd.send_exec && free_found && !too_long) begin
        timer[free_idx] <= req.dest_known ? timer_send : timer_res;
      end
      if (cmd.ack_step && ack_match) begin
        timer[cur] <= '0;
      end
      if (cmd.tick_eval && !t_zero) begin
        timer[cur] <= (t_neg && hit) ? timer_send : t_step;
      end
    end
  end

  // Item latch, slot ids, destinations, tick kind and held result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= request;
    end
    if (cmd.send_exec && free_found && !too_long) begin
      sid[free_idx]   <= req.new_id;
      sdest[free_idx] <= req.dest_handle;
    end
    if (cmd.tick_eval) begin
      kind_resolve <= t_neg;
    end
    if (cmd.tick_finish && mod_zero && !kind_resolve && hit) begin
      sid[cur] <= id_bumped;
    end
    if (push) begin
      pend <= push_item;
    end
  end

  // Hold stage and output strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (push) begin
        pend_valid <= 1'b1;
        strobe     <= pend_valid;
      end else if (cmd.flush) begin
        pend_valid <= 1'b0;
        strobe     <= pend_valid;
      end
    end
  end

  // Output payload; last is set when no further result follows
  always_ff @(posedge clk) begin
    if ((push || cmd.flush) && pend_valid) begin
      result <= {pend.slot_index, pend.action, pend.msg_id, pend.dest_out, !push};
    end
  end

endmodule

// File: rtl/core/ars_ctrl.sv
// Controller: sequences send, ack and tick items over the datapath.
`timescale 1ns / 1ps

module ars_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ars_pkg::dp_stat_t stat,
  output ars_pkg::dp_cmd_t  cmd,
  output logic              busy
);

  ars_pkg::state_t state;
  ars_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ars_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ars_pkg::ST_IDLE: begin
        if (start) begin
          priority if (stat.req_op == ars_pkg::OP_SEND) begin
            state_next = ars_pkg::ST_SEND;
          end else if (stat.req_op == ars_pkg::OP_ACK) begin
            state_next = ars_pkg::ST_ACK;
          end else if (stat.req_op == ars_pkg::OP_TICK) begin
            state_next = ars_pkg::ST_TICK;
          end else begin
            state_next = ars_pkg::ST_IDLE;
          end
        end
      end
      ars_pkg::ST_SEND: begin
        state_next = stat.send_ok ? ars_pkg::ST_SEND2 : ars_pkg::ST_FLUSH;
      end
      ars_pkg::ST_SEND2: begin
        state_next = ars_pkg::ST_FLUSH;
      end
      ars_pkg::ST_ACK: begin
        if (stat.ack_match || stat.cur_last) begin
          state_next = ars_pkg::ST_FLUSH;
        end
      end
      ars_pkg::ST_TICK: begin
        if (stat.tick_needs_mod) begin
          state_next = ars_pkg::ST_TICK_WAIT;
        end else if (stat.cur_last) begin
          state_next = ars_pkg::ST_FLUSH;
        end
      end
      ars_pkg::ST_TICK_WAIT: begin
        if (stat.mod_done) begin
          state_next = stat.cur_last ? ars_pkg::ST_FLUSH : ars_pkg::ST_TICK;
        end
      end
      ars_pkg::ST_FLUSH: begin
        state_next = ars_pkg::ST_IDLE;
      end
      default: state_next = ars_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd  = '0;
    busy = (state != ars_pkg::ST_IDLE);
    unique case (state)
      ars_pkg::ST_IDLE: begin
        cmd.load      = start;
        cmd.cur_clear = start;
      end
      ars_pkg::ST_SEND: begin
        cmd.send_exec = 1'b1;
      end
      ars_pkg::ST_SEND2: begin
        cmd.send_second = 1'b1;
      end
      ars_pkg::ST_ACK: begin
        cmd.ack_step = 1'b1;
        cmd.cur_inc  = !stat.ack_match && !stat.cur_last;
      end
      ars_pkg::ST_TICK: begin
        cmd.tick_eval = 1'b1;
        cmd.cur_inc   = !stat.tick_needs_mod && !stat.cur_last;
      end
      ars_pkg::ST_TICK_WAIT: begin
        cmd.tick_finish = stat.mod_done;
        cmd.cur_inc     = stat.mod_done && !stat.cur_last;
      end
      ars_pkg::ST_FLUSH: begin
        cmd.flush = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/core/ack_retransmit_slot_manager_unit.sv
// Top level of the acknowledged-retransmission slot manager.
// One item at a time; busy stays high from acceptance until its last result is staged.
// Send: SEND, SEND2, FLUSH (no SEND2 if refused); SEND2 and FLUSH strobe its results.
// Ack: walks slot ids one per cycle until a match or the last slot, then FLUSH.
// Tick: TICK per slot, TICK_WAIT on the 7-step remainder unit if needed, then FLUSH.
// Synchronous reset frees all slots and restores register defaults at once.
`timescale 1ns / 1ps

module ack_retransmit_slot_manager_unit #(
  parameter int SLOTS = 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  ars_pkg::request_t             request,
  output logic                          strobe,
  output ars_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ars_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ars_pkg::CFG_DATA_W-1:0] cfg_data
);

  ars_pkg::dp_cmd_t  cmd;
  ars_pkg::dp_stat_t stat;

  // Registers are always writable
  assign cfg_ready = 1'b1;

  ars_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  ars_datapath #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .request   (request),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result),
    .strobe    (strobe)
  );

endmodule

// File: rtl/core/ars_checker.sv
// Port-level checks of the slot manager and their bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ars_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input ars_pkg::request_t request,
  input logic              strobe,
  input ars_pkg::result_t  result
);

  logic accept_item;
  logic single_res;
  logic accept_res;
  logic second_res;

  // Send, ack or tick item taken at this edge
  assign accept_item = start && !busy &&
                       ((request.op == ars_pkg::OP_SEND) || (request.op == ars_pkg::OP_ACK) ||
                        (request.op == ars_pkg::OP_TICK));

  // Outcomes that always come alone
  assign single_res = strobe &&
                      ((result.action == ars_pkg::ACT_NOSLOT) ||
                       (result.action == ars_pkg::ACT_TOOLONG) ||
                       (result.action == ars_pkg::ACT_ACKED) ||
                       (result.action == ars_pkg::ACT_UNMATCHED));

  // First and closing results of an accepted send
  assign accept_res = strobe && (result.action == ars_pkg::ACT_ACCEPTED);
  assign second_res = strobe && result.last &&
                      ((result.action == ars_pkg::ACT_TRANSMIT) ||
                       (result.action == ars_pkg::ACT_NAMEREQ));

  // Reset leaves the block idle with no result on the ports
  `ASSERT_ALWAYS(a_rst_idle, clk, rst |=> !busy && !strobe, "not idle after reset")

  // A send, ack or tick item keeps the block busy in the next cycle
  `ASSERT_ON(a_busy_after_accept, clk, rst, accept_item |=> busy, "block idle after accept")

  // Single-result outcomes always close their item
  `ASSERT_ON(a_single_last, clk, rst, single_res |-> result.last, "single result not marked last")

  // An accepted send is followed at once by its closing transmit or name request
  `ASSERT_ON(a_accept_pair, clk, rst, accept_res |=> second_res, "send lacks its second result")

endmodule

bind ack_retransmit_slot_manager_unit ars_checker u_ars_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .request (request),
  .strobe  (strobe),
  .result  (result)
);
